// ----- rtl/roimp_pkg.sv -----
// roimp_pkg: shared constants and types for the ROI max pooling block.
// Used by roi_max_pooling_forward. No dependencies.
package roimp_pkg;

    // default sizes, handed down as top level parameters
    localparam int DEF_NUM_CHANNELS = 64;
    localparam int DEF_MAX_HEIGHT   = 64;
    localparam int DEF_MAX_WIDTH    = 64;
    localparam int DEF_MAX_BINS     = 8;

    // bin slots per axis, fixed by the 3-bit bin index fields
    localparam int BIN_SLOTS = 8;

    // stream widths
    localparam int S_TDATA_W = 104;  // 98 bits of fields padded to bytes
    localparam int M_TDATA_W = 40;   // 36 bits of fields padded to bytes

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SPATIAL_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BINS_PER_SIDE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH     = 2'd3;

    localparam logic [15:0] RST_SPATIAL_SCALE = 16'd4096;
    localparam logic [3:0]  RST_BINS_PER_SIDE = 4'd7;
    localparam logic [6:0]  RST_MAP_HEIGHT    = 7'd64;
    localparam logic [6:0]  RST_MAP_WIDTH     = 7'd64;

    // input beat kinds carried on s_tuser
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_POOL  = 1'b1;

    // empty bin answer
    localparam logic [15:0] EMPTY_VALUE = 16'h8000;
    localparam logic [6:0]  EMPTY_POS   = 7'h7F;

    // map positions and bin bounds
    typedef logic [6:0] pos_t;

endpackage

// ----- rtl/roimp_ram.sv -----
// roimp_ram: generic single-write, single-read RAM with a registered read.
// Depends on nothing; contents undefined until written.
module roimp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/roi_max_pooling_forward.sv -----
// roi_max_pooling_forward: ROI max pooling over a stored Q8.8 feature map.
// Write beats store one map word. Pool beats: corner scaling, then per axis a
// bin-width division and edge generation, then per bin a setup step, a scan of
// its cells, a drain step when not empty and an emit step; the scan reads one
// map word a cycle from the single read port. Results go out in a register.
// Reset (aresetn, synchronous, low): config to defaults, no clearing pass.
// Depends on roimp_pkg and roimp_ram.
module roi_max_pooling_forward #(
    parameter int NUM_CHANNELS = roimp_pkg::DEF_NUM_CHANNELS,
    parameter int MAX_HEIGHT   = roimp_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_WIDTH    = roimp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_BINS     = roimp_pkg::DEF_MAX_BINS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration writes
    input  logic                             cfg_we,
    input  logic [roimp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [roimp_pkg::CFG_DATA_W-1:0] cfg_data,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // channel, row, column, feature_value, region_left, region_top,
    // region_right, region_bottom, zero pad
    input  logic [roimp_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                             s_tuser,  // action
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // max_value, max_row, max_column, bin_row, bin_column, zero pad
    output logic [roimp_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                             m_tlast   // last
);

    import roimp_pkg::*;

    localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ADDR_W = CH_W + ROW_W + COL_W;
    localparam int DEPTH  = 2 ** ADDR_W;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL, ST_DSET, ST_DIV, ST_DFIX, ST_EDGE,
        ST_BIN, ST_SCAN, ST_DRAIN, ST_EMIT
    } state_t;

    state_t state_reg;

    // configuration
    logic [15:0] spatial_scale_reg;
    logic [3:0]  bins_per_side_reg;
    pos_t        map_height_reg;
    pos_t        map_width_reg;

    // input beat fields
    logic [5:0]  in_channel, in_row, in_column;
    logic [15:0] in_value;
    logic [15:0] in_corner [4];

    assign in_channel   = s_tdata[5:0];
    assign in_row       = s_tdata[11:6];
    assign in_column    = s_tdata[17:12];
    assign in_value     = s_tdata[33:18];
    assign in_corner[0] = s_tdata[49:34];
    assign in_corner[1] = s_tdata[65:50];
    assign in_corner[2] = s_tdata[81:66];
    assign in_corner[3] = s_tdata[97:82];

    // pool job registers
    logic [5:0]  ch_reg;
    logic        ch_ok_reg;
    logic [15:0] corner_reg [4];
    logic [31:0] prod_reg;
    logic [12:0] sc_reg [4];    // scaled corners: left, top, right, bottom
    logic [4:0]  cnt_reg;
    logic        axis_reg;      // 0 columns, 1 rows
    logic        neg_reg;
    logic [20:0] quo_reg;
    logic [4:0]  rem_reg;
    logic signed [23:0] qd_reg, q_reg, base_reg;
    logic [3:0]  rd_reg, r_reg;
    logic [3:0]  i_reg;
    pos_t        xlo_reg [BIN_SLOTS];
    pos_t        xhi_reg [BIN_SLOTS];
    pos_t        ylo_reg [BIN_SLOTS];
    pos_t        yhi_reg [BIN_SLOTS];
    logic [2:0]  j_reg, k_reg;
    pos_t        y_reg, x_reg;
    logic        rd_v_reg;
    pos_t        rd_y_reg, rd_x_reg;
    logic        best_v_reg;
    logic [15:0] best_reg;
    pos_t        best_y_reg, best_x_reg;

    // output register
    logic        m_tvalid_reg;
    logic        m_tlast_reg;
    logic [15:0] m_value_reg;
    pos_t        m_row_reg, m_col_reg;
    logic [2:0]  m_brow_reg, m_bcol_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = {4'b0, m_bcol_reg, m_brow_reg, m_col_reg, m_row_reg, m_value_reg};

    logic s_acc;
    assign s_acc = s_tvalid & s_tready;

    // saturated configuration
    logic [3:0] n_sat;
    pos_t       h_lim, w_lim;

    always_comb begin
        if (bins_per_side_reg == 4'd0) begin
            n_sat = 4'd1;
        end else if ({28'b0, bins_per_side_reg} > MAX_BINS) begin
            n_sat = 4'(MAX_BINS);
        end else begin
            n_sat = bins_per_side_reg;
        end
        h_lim = ({25'b0, map_height_reg} > MAX_HEIGHT) ? 7'(MAX_HEIGHT) : map_height_reg;
        w_lim = ({25'b0, map_width_reg} > MAX_WIDTH) ? 7'(MAX_WIDTH) : map_width_reg;
    end

    // feature map
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [15:0]       ram_rdata;
    logic [15:0]       wch16, wrow16, wcol16, rch16, ry16, rx16;

    always_comb begin
        wch16  = {10'b0, in_channel};
        wrow16 = {10'b0, in_row};
        wcol16 = {10'b0, in_column};
        rch16  = {10'b0, ch_reg};
        ry16   = {9'b0, y_reg};
        rx16   = {9'b0, x_reg};
        ram_we = s_acc && (s_tuser == ACT_WRITE)
                 && ({26'b0, in_channel} < NUM_CHANNELS)
                 && ({26'b0, in_row} < MAX_HEIGHT)
                 && ({26'b0, in_column} < MAX_WIDTH);
        ram_waddr = {wch16[CH_W-1:0], wrow16[ROW_W-1:0], wcol16[COL_W-1:0]};
        ram_raddr = {rch16[CH_W-1:0], ry16[ROW_W-1:0], rx16[COL_W-1:0]};
    end

    roimp_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // corner scaling: round half up of the Q12.20 product
    logic [32:0] prod_rnd;
    logic [12:0] scaled;
    assign prod_rnd = {1'b0, prod_reg} + 33'h80000;
    assign scaled   = prod_rnd[32:20];

    // span setup for the current axis
    logic [12:0]        sp_s, sp_e, d_mag;
    logic signed [13:0] d_span;

    always_comb begin
        sp_s   = axis_reg ? sc_reg[1] : sc_reg[0];
        sp_e   = axis_reg ? sc_reg[3] : sc_reg[2];
        d_span = $signed({1'b0, sp_e}) + 14'sd1 - $signed({1'b0, sp_s});
        d_mag  = d_span[13] ? 13'(-d_span) : d_span[12:0];
    end

    // restoring divider step by n
    logic [4:0] div_t;
    logic       div_ge;
    assign div_t  = {rem_reg[3:0], quo_reg[20]};
    assign div_ge = (div_t >= {1'b0, n_sat});

    // edge generation
    logic signed [23:0] edge_v, edge_c;
    logic [15:0]        edge_fl, edge_cl;
    pos_t               lim, lo_v, hi_v;
    logic [4:0]         rsum;
    logic               rwrap;
    logic [3:0]         i_prev;

    always_comb begin
        edge_v  = base_reg + q_reg;
        edge_c  = edge_v + 24'sd255;
        edge_fl = edge_v[23:8];
        edge_cl = edge_c[23:8];
        lim     = axis_reg ? h_lim : w_lim;
        lo_v    = (edge_fl > {9'b0, lim}) ? lim : edge_fl[6:0];
        hi_v    = (edge_cl > {9'b0, lim}) ? lim : edge_cl[6:0];
        rsum    = {1'b0, r_reg} + {1'b0, rd_reg};
        rwrap   = (rsum >= {1'b0, n_sat});
        i_prev  = i_reg - 4'd1;
    end

    // bin bounds
    pos_t y0, y1, x0, x1;
    logic bin_empty, bin_last;

    always_comb begin
        y0 = ylo_reg[j_reg];
        y1 = yhi_reg[j_reg];
        x0 = xlo_reg[k_reg];
        x1 = xhi_reg[k_reg];
        bin_empty = !ch_ok_reg || (y0 >= y1) || (x0 >= x1);
        bin_last  = ({1'b0, j_reg} == n_sat - 4'd1) && ({1'b0, k_reg} == n_sat - 4'd1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            m_tvalid_reg      <= 1'b0;
            rd_v_reg          <= 1'b0;
            spatial_scale_reg <= RST_SPATIAL_SCALE;
            bins_per_side_reg <= RST_BINS_PER_SIDE;
            map_height_reg    <= RST_MAP_HEIGHT;
            map_width_reg     <= RST_MAP_WIDTH;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_SPATIAL_SCALE: spatial_scale_reg <= cfg_data;
                    CFG_BINS_PER_SIDE: bins_per_side_reg <= cfg_data[3:0];
                    CFG_MAP_HEIGHT:    map_height_reg    <= cfg_data[6:0];
                    CFG_MAP_WIDTH:     map_width_reg     <= cfg_data[6:0];
                    default: ;
                endcase
            end

            // the emit step reloads the output register itself
            if (m_tvalid_reg && m_tready && (state_reg != ST_EMIT)) begin
                m_tvalid_reg <= 1'b0;
            end

            // compare stage, behind the registered read
            rd_v_reg <= (state_reg == ST_SCAN);
            if (rd_v_reg && (!best_v_reg || ($signed(ram_rdata) > $signed(best_reg)))) begin
                best_v_reg <= 1'b1;
                best_reg   <= ram_rdata;
                best_y_reg <= rd_y_reg;
                best_x_reg <= rd_x_reg;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_acc && (s_tuser == ACT_POOL)) begin
                        ch_reg     <= in_channel;
                        ch_ok_reg  <= ({26'b0, in_channel} < NUM_CHANNELS);
                        corner_reg <= in_corner;
                        cnt_reg    <= 5'd0;
                        state_reg  <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    // one shared multiplier, product registered before rounding
                    if (cnt_reg < 5'd4) begin
                        prod_reg <= corner_reg[cnt_reg[1:0]] * spatial_scale_reg;
                    end
                    if (cnt_reg != 5'd0) begin
                        sc_reg[2'(cnt_reg - 5'd1)] <= scaled;
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd4) begin
                        axis_reg  <= 1'b0;
                        state_reg <= ST_DSET;
                    end
                end
                ST_DSET: begin
                    neg_reg   <= d_span[13];
                    quo_reg   <= {d_mag, 8'b0};
                    rem_reg   <= 5'd0;
                    cnt_reg   <= 5'd0;
                    base_reg  <= {3'b0, sp_s, 8'b0};
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    quo_reg <= {quo_reg[19:0], div_ge};
                    rem_reg <= div_ge ? (div_t - {1'b0, n_sat}) : div_t;
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd20) begin
                        state_reg <= ST_DFIX;
                    end
                end
                ST_DFIX: begin
                    // floor division for a downward span
                    if (neg_reg && (rem_reg != 5'd0)) begin
                        qd_reg <= -$signed({3'b0, quo_reg}) - 24'sd1;
                        rd_reg <= n_sat - rem_reg[3:0];
                    end else if (neg_reg) begin
                        qd_reg <= -$signed({3'b0, quo_reg});
                        rd_reg <= 4'd0;
                    end else begin
                        qd_reg <= $signed({3'b0, quo_reg});
                        rd_reg <= rem_reg[3:0];
                    end
                    q_reg     <= 24'sd0;
                    r_reg     <= 4'd0;
                    i_reg     <= 4'd0;
                    state_reg <= ST_EDGE;
                end
                ST_EDGE: begin
                    if (i_reg < n_sat) begin
                        if (axis_reg) begin
                            ylo_reg[i_reg[2:0]] <= lo_v;
                        end else begin
                            xlo_reg[i_reg[2:0]] <= lo_v;
                        end
                    end
                    if (i_reg != 4'd0) begin
                        if (axis_reg) begin
                            yhi_reg[i_prev[2:0]] <= hi_v;
                        end else begin
                            xhi_reg[i_prev[2:0]] <= hi_v;
                        end
                    end
                    if (rwrap) begin
                        r_reg <= 4'(rsum - {1'b0, n_sat});
                        q_reg <= q_reg + qd_reg + 24'sd1;
                    end else begin
                        r_reg <= rsum[3:0];
                        q_reg <= q_reg + qd_reg;
                    end
                    i_reg <= i_reg + 4'd1;
                    if (i_reg == n_sat) begin
                        if (axis_reg) begin
                            j_reg     <= 3'd0;
                            k_reg     <= 3'd0;
                            state_reg <= ST_BIN;
                        end else begin
                            axis_reg  <= 1'b1;
                            state_reg <= ST_DSET;
                        end
                    end
                end
                ST_BIN: begin
                    best_v_reg <= 1'b0;
                    y_reg      <= y0;
                    x_reg      <= x0;
                    state_reg  <= bin_empty ? ST_EMIT : ST_SCAN;
                end
                ST_SCAN: begin
                    rd_y_reg <= y_reg;
                    rd_x_reg <= x_reg;
                    if (x_reg + 7'd1 == x1) begin
                        x_reg <= x0;
                        y_reg <= y_reg + 7'd1;
                        if (y_reg + 7'd1 == y1) begin
                            state_reg <= ST_DRAIN;
                        end
                    end else begin
                        x_reg <= x_reg + 7'd1;
                    end
                end
                ST_DRAIN: begin
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_value_reg  <= best_v_reg ? best_reg : EMPTY_VALUE;
                        m_row_reg    <= best_v_reg ? best_y_reg : EMPTY_POS;
                        m_col_reg    <= best_v_reg ? best_x_reg : EMPTY_POS;
                        m_brow_reg   <= j_reg;
                        m_bcol_reg   <= k_reg;
                        m_tlast_reg  <= bin_last;
                        if (bin_last) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            if ({1'b0, k_reg} == n_sat - 4'd1) begin
                                k_reg <= 3'd0;
                                j_reg <= j_reg + 3'd1;
                            end else begin
                                k_reg <= k_reg + 3'd1;
                            end
                            state_reg <= ST_BIN;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    // map reads only in flight while scanning a bin
    a_read_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_v_reg |-> (state_reg == ST_SCAN || state_reg == ST_DRAIN))
        else $error("map read outside a bin scan");

    // a reported maximum lies inside its bin
    a_best_in_bin: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && best_v_reg) |->
            (best_y_reg >= y0 && best_y_reg < y1 && best_x_reg >= x0 && best_x_reg < x1))
        else $error("bin maximum outside bin bounds");

    // a pool beat starts corner scaling
    a_pool_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_tuser == ACT_POOL) |=> (state_reg == ST_MUL))
        else $error("pool beat did not start a job");

    // a result beat is only loaded from the emit step
    a_emit_only: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == ST_EMIT))
        else $error("result raised outside emit");
`endif

endmodule
